// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/bta_pkg.sv
// shared types and constants of the bakery ticket arbiter
package bta_pkg;

    localparam int NUM_CLIENTS_DEF = 8;
    localparam int TICKET_BITS_DEF = 16;

    localparam int REQ_W      = 2;
    localparam int CLIENT_W   = 3;
    localparam int TICKET_O_W = 16;

    localparam logic [REQ_W-1:0] REQ_TAKE    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    // scan token control travelling along the cell row
    typedef struct packed {
        logic                valid;
        logic [CLIENT_W-1:0] client;
    } t_ctl;

endpackage

// File: sv/bta_if.sv
// request and response channel interfaces
interface bta_req_if;
    logic                          valid;
    logic                          ready;
    logic [bta_pkg::REQ_W-1:0]     req_type;
    logic [bta_pkg::CLIENT_W-1:0]  client;

    modport source (output valid, output req_type, output client, input ready);
    modport sink   (input valid, input req_type, input client, output ready);
endinterface

interface bta_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           granted;
    logic [bta_pkg::TICKET_O_W-1:0] ticket;
    logic                           status;

    modport source (output valid, output granted, output ticket, output status,
                    input ready);
    modport sink   (input valid, input granted, input ticket, input status,
                    output ready);
endinterface

// File: sv/bta_cell.sv
// one client cell: holds a ticket and folds it into the passing scan token
module bta_cell #(
    parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF,
    parameter int IDX_W       = 3,
    parameter int INDEX       = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bta_pkg::t_ctl          i_ctl,
    input  logic [TICKET_BITS-1:0] i_max,
    input  logic [TICKET_BITS-1:0] i_min_tkt,
    input  logic [IDX_W-1:0]       i_min_idx,
    input  logic                   i_min_found,
    input  logic                   i_others,
    input  logic [TICKET_BITS-1:0] i_mine,
    input  logic                   i_wr_en,
    input  logic [TICKET_BITS-1:0] i_wr_val,
    output bta_pkg::t_ctl          o_ctl,
    output logic [TICKET_BITS-1:0] o_max,
    output logic [TICKET_BITS-1:0] o_min_tkt,
    output logic [IDX_W-1:0]       o_min_idx,
    output logic                   o_min_found,
    output logic                   o_others,
    output logic [TICKET_BITS-1:0] o_mine
);

    logic [TICKET_BITS-1:0] r_ticket;
    bta_pkg::t_ctl          r_ctl;
    logic [TICKET_BITS-1:0] r_max, r_min_tkt, r_mine;
    logic [IDX_W-1:0]       r_min_idx;
    logic                   r_min_found, r_others;

    logic w_hit, w_nz, w_lower;

    assign w_hit   = i_ctl.valid && (32'(i_ctl.client) == INDEX);
    assign w_nz    = (r_ticket != '0);
    // strict compare keeps the earlier (lower index) holder on a tie
    assign w_lower = w_nz && (!i_min_found || (r_ticket < i_min_tkt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticket <= '0;
        end else if (i_wr_en) begin
            r_ticket <= i_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max       <= (r_ticket > i_max) ? r_ticket : i_max;
        r_min_tkt   <= w_lower ? r_ticket : i_min_tkt;
        r_min_idx   <= w_lower ? IDX_W'(INDEX) : i_min_idx;
        r_min_found <= i_min_found || w_nz;
        r_others    <= i_others || (w_nz && !w_hit);
        r_mine      <= w_hit ? r_ticket : i_mine;
    end

    assign o_ctl       = r_ctl;
    assign o_max       = r_max;
    assign o_min_tkt   = r_min_tkt;
    assign o_min_idx   = r_min_idx;
    assign o_min_found = r_min_found;
    assign o_others    = r_others;
    assign o_mine      = r_mine;

endmodule

// File: sv/bakery_ticket_arbiter.sv
// top level of the bakery ticket arbiter: cell row, sequencer and response register
//
//  channel  | dir | fields                   | transfer
//  ---------+-----+--------------------------+---------------------
//  i_req    | in  | req_type, client         | valid & ready
//  o_rsp    | out | granted, ticket, status  | valid & ready
//
// a request sends one scan token along the cell row, one cell per cycle; the
// row result is registered, then the finish state updates the ticket and loads
// the response. an out-of-range client skips the scan and goes straight to finish.
// reset clears all tickets at once, so requests are taken right after reset.
// a stalled response holds the finished request; a new request is taken
// while the response waits, and its scan result waits in turn.
`include "assert_macros.svh"

module bakery_ticket_arbiter #(
    parameter int NUM_CLIENTS = bta_pkg::NUM_CLIENTS_DEF,
    parameter int TICKET_BITS = bta_pkg::TICKET_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bta_req_if.sink   i_req,
    bta_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(NUM_CLIENTS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    bta_pkg::t_ctl          w_ctl     [NUM_CLIENTS+1];
    logic [TICKET_BITS-1:0] w_max     [NUM_CLIENTS+1];
    logic [TICKET_BITS-1:0] w_min_tkt [NUM_CLIENTS+1];
    logic [IDX_W-1:0]       w_min_idx [NUM_CLIENTS+1];
    logic                   w_min_fnd [NUM_CLIENTS+1];
    logic                   w_others  [NUM_CLIENTS+1];
    logic [TICKET_BITS-1:0] w_mine    [NUM_CLIENTS+1];

    logic [NUM_CLIENTS-1:0] w_wr_sel;
    logic [NUM_CLIENTS-1:0] w_tok_valid;
    logic [TICKET_BITS-1:0] w_wr_val;

    logic                           r_oor;
    logic [bta_pkg::REQ_W-1:0]      r_req;
    logic [bta_pkg::CLIENT_W-1:0]   r_client;
    logic [TICKET_BITS-1:0]         r_fin_max, r_fin_mine;
    logic [IDX_W-1:0]               r_fin_min_idx;
    logic                           r_fin_min_fnd, r_fin_others;

    logic                           r_out_valid;
    logic                           r_granted, r_status;
    logic [bta_pkg::TICKET_O_W-1:0] r_ticket;

    logic                   w_accept, w_in_range, w_fire, w_ovf, w_do_wr, w_lowest;
    logic                   n_granted, n_status;
    logic [TICKET_BITS-1:0] n_ticket;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_range  = (32'(i_req.client) < NUM_CLIENTS);

    // token launch into the first cell
    assign w_ctl[0].valid  = w_accept && w_in_range;
    assign w_ctl[0].client = i_req.client;
    assign w_max[0]        = '0;
    assign w_min_tkt[0]    = '0;
    assign w_min_idx[0]    = '0;
    assign w_min_fnd[0]    = 1'b0;
    assign w_others[0]     = 1'b0;
    assign w_mine[0]       = '0;

    for (genvar k = 0; k < NUM_CLIENTS; k++) begin : g_cell
        bta_cell #(
            .TICKET_BITS (TICKET_BITS),
            .IDX_W       (IDX_W),
            .INDEX       (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[k]),
            .i_max       (w_max[k]),
            .i_min_tkt   (w_min_tkt[k]),
            .i_min_idx   (w_min_idx[k]),
            .i_min_found (w_min_fnd[k]),
            .i_others    (w_others[k]),
            .i_mine      (w_mine[k]),
            .i_wr_en     (w_wr_sel[k]),
            .i_wr_val    (w_wr_val),
            .o_ctl       (w_ctl[k+1]),
            .o_max       (w_max[k+1]),
            .o_min_tkt   (w_min_tkt[k+1]),
            .o_min_idx   (w_min_idx[k+1]),
            .o_min_found (w_min_fnd[k+1]),
            .o_others    (w_others[k+1]),
            .o_mine      (w_mine[k+1])
        );
        assign w_tok_valid[k] = w_ctl[k+1].valid;
        assign w_wr_sel[k]    = w_do_wr && (32'(r_client) == k);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_range ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (w_ctl[NUM_CLIENTS].valid) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_oor    <= !w_in_range;
            r_req    <= i_req.req_type;
            r_client <= i_req.client;
        end
        if (r_state == S_SCAN && w_ctl[NUM_CLIENTS].valid) begin
            r_fin_max     <= w_max[NUM_CLIENTS];
            r_fin_mine    <= w_mine[NUM_CLIENTS];
            r_fin_min_idx <= w_min_idx[NUM_CLIENTS];
            r_fin_min_fnd <= w_min_fnd[NUM_CLIENTS];
            r_fin_others  <= w_others[NUM_CLIENTS];
        end
    end

    // result and ticket update
    assign w_fire   = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);
    assign w_ovf    = &r_fin_max;
    assign w_lowest = r_fin_min_fnd && (32'(r_fin_min_idx) == 32'(r_client));
    assign w_wr_val = (r_req == bta_pkg::REQ_TAKE) ? TICKET_BITS'(r_fin_max + 1'b1) : '0;
    assign w_do_wr  = w_fire && !r_oor &&
                      (((r_req == bta_pkg::REQ_TAKE) && !w_ovf) ||
                       (r_req == bta_pkg::REQ_RELEASE));

    always_comb begin
        n_granted = w_lowest;
        n_ticket  = r_fin_mine;
        n_status  = 1'b0;
        if (r_oor) begin
            n_granted = 1'b0;
            n_ticket  = '0;
        end else if (r_req == bta_pkg::REQ_TAKE) begin
            if (w_ovf) begin
                n_status = 1'b1;
            end else begin
                // fresh ticket is above every other, so only a lone holder wins
                n_granted = !r_fin_others;
                n_ticket  = w_wr_val;
            end
        end else if (r_req == bta_pkg::REQ_RELEASE) begin
            n_granted = 1'b0;
            n_ticket  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_granted <= n_granted;
            r_ticket  <= bta_pkg::TICKET_O_W'(n_ticket);
            r_status  <= n_status;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.granted = r_granted;
    assign o_rsp.ticket  = r_ticket;
    assign o_rsp.status  = r_status;

    `ASSERT_IMPLIES(a_idle_row_empty, i_clk, i_rst_n, r_state == S_IDLE, w_tok_valid == '0)
    `ASSERT_ALWAYS(a_one_token, i_clk, i_rst_n, $countones(w_tok_valid) <= 1)
    `ASSERT_IMPLIES(a_wr_in_finish, i_clk, i_rst_n, w_wr_sel != '0, r_state == S_FINISH)
    `ASSERT_ALWAYS(a_wr_onehot, i_clk, i_rst_n, $onehot0(w_wr_sel))

endmodule
